[hdl/ivau_pkg.sv]
package ivau_pkg;

  // Lane and pipeline shape
  localparam int LANES        = 3;
  localparam int LANE_STAGES  = 7;
  localparam int MERGE_STAGES = 6;
  localparam int PIPE_DEPTH   = LANE_STAGES + MERGE_STAGES;

  // Field widths
  localparam int RAW_W     = 16;
  localparam int QUAT_W    = 32;
  localparam int OUT_W     = 32;
  localparam int CFG_W     = 16;
  localparam int CFG_IDX_W = 2;
  localparam int IN_W      = 3 * RAW_W + 4 * QUAT_W;
  localparam int OUT_DW    = 4 * OUT_W;

  // Internal widths
  localparam int GAIN_W   = 17;  // 16-bit signed word plus a power of two up to 2^15
  localparam int PROD_W   = 64;
  localparam int ACC_W    = 64;  // acceleration in Q29, held within +-2^62
  localparam int VS_W     = 42;  // vector before the offset, held within +-2^40
  localparam int RA_W     = 51;  // gravity-free acceleration in Q16
  localparam int RA_LO_W  = 26;
  localparam int DOT_W    = 44;  // dot product in Q24
  localparam int DOT_LO_W = 22;

  // Fixed-point points and limits
  localparam int VEC_FRAC  = 29;
  localparam int LIM_V_EXP = 40;
  localparam int LIM_A_EXP = 62;
  localparam int RA_SHIFT  = 13;
  localparam int DOT_SHIFT = 21;
  localparam int RES_SHIFT = 24;

  // Register indexes
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_X     = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_Y     = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BIAS_Z     = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_SCALE_WORD = 2'd3;

  // Per-lane operation: vector = a*b +/- c*d, optionally minus one
  typedef struct packed {
    logic sub_cd;
    logic sub_one;
  } lane_op_t;

  // Stage load enables from the pipeline control
  typedef struct packed {
    logic [MERGE_STAGES-1:0] merge_en;
    logic [LANE_STAGES-1:0]  lane_en;
  } pipe_en_t;

endpackage

[hdl/ivau_pipe_ctrl.sv]
module ivau_pipe_ctrl
  import ivau_pkg::*;
(
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     in_valid_i,
  output logic     in_ready_o,
  output logic     out_valid_o,
  input  logic     out_ready_i,
  output pipe_en_t en_o
);

  logic [PIPE_DEPTH-1:0] valid_q, valid_d;
  logic [PIPE_DEPTH-1:0] en;
  logic [PIPE_DEPTH-1:0] shift_in;

  // A stage may load when the output drains or a bubble sits at or after it
  always_comb begin
    for (int k = 0; k < PIPE_DEPTH; k++) begin
      en[k] = out_ready_i || (|(~valid_q & ({PIPE_DEPTH{1'b1}} << k)));
    end
  end

  // Advance valid bits where enabled, hold elsewhere
  assign shift_in = {valid_q[PIPE_DEPTH-2:0], in_valid_i};
  assign valid_d  = (en & shift_in) | (~en & valid_q);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  assign in_ready_o      = en[0];
  assign out_valid_o     = valid_q[PIPE_DEPTH-1];
  assign en_o.lane_en    = en[LANE_STAGES-1:0];
  assign en_o.merge_en   = en[PIPE_DEPTH-1:LANE_STAGES];

endmodule

[hdl/ivau_lane.sv]
module ivau_lane
  import ivau_pkg::*;
#(
  parameter int BIAS_SHIFT     = 6,
  parameter int SCALE_SHIFT    = 7,
  parameter int ACCEL_SHIFT    = 12,
  parameter int QUAT_FRAC_BITS = 30
) (
  input  logic                     clk_i,
  input  logic [LANE_STAGES-1:0]   en_i,
  input  lane_op_t                 op_i,
  input  logic signed [RAW_W-1:0]  raw_i,
  input  logic signed [CFG_W-1:0]  bias_i,
  input  logic signed [GAIN_W-1:0] gain_i,
  input  logic signed [QUAT_W-1:0] qa_i,
  input  logic signed [QUAT_W-1:0] qb_i,
  input  logic signed [QUAT_W-1:0] qc_i,
  input  logic signed [QUAT_W-1:0] qd_i,
  output logic signed [OUT_W-1:0]  vert_o,
  output logic signed [PROD_W-1:0] prod_o
);

  localparam int CAL_W  = RAW_W + BIAS_SHIFT + 1;
  localparam int CALG_W = CAL_W + GAIN_W;
  localparam int EA     = VEC_FRAC - BIAS_SHIFT - SCALE_SHIFT - ACCEL_SHIFT;
  localparam int EV     = VEC_FRAC + 1 - 2 * QUAT_FRAC_BITS;
  localparam int D_W    = PROD_W + 1;
  localparam int VW     = D_W + 3;
  localparam int X_W    = ACC_W + 1;
  localparam int PPL_W  = OUT_W + RA_LO_W + 1;
  localparam int PPH_W  = OUT_W + RA_W - RA_LO_W;
  localparam int FULL_W = OUT_W + RA_W;

  localparam logic signed [VW-1:0]    V_HI     = VW'(1) <<< LIM_V_EXP;
  localparam logic signed [VW-1:0]    V_LO     = -V_HI;
  localparam logic signed [VS_W-1:0]  ONE_Q29  = VS_W'(1) <<< VEC_FRAC;
  localparam logic signed [X_W-1:0]   RA_RND   = X_W'(1) <<< (RA_SHIFT - 1);

  // Stage 0: quaternion products and calibrated axis times gain
  logic signed [CAL_W-1:0]  cal;
  logic signed [PROD_W-1:0] pab_q, pcd_q;
  logic signed [CALG_W-1:0] calg_q;

  assign cal = (CAL_W'(raw_i) <<< BIAS_SHIFT) - CAL_W'(bias_i);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      pab_q  <= qa_i * qb_i;
      pcd_q  <= qc_i * qd_i;
      calg_q <= cal * gain_i;
    end
  end

  // Stage 1: combine products, scale acceleration to Q29
  logic signed [D_W-1:0]   d_q;
  logic signed [ACC_W-1:0] acc_d, acc1_q;

  if (EA >= 0) begin : g_acc_up
    localparam int EXT_W = (CALG_W + EA > X_W) ? CALG_W + EA : X_W;
    localparam logic signed [EXT_W-1:0] A_HI = EXT_W'(1) <<< LIM_A_EXP;
    localparam logic signed [EXT_W-1:0] A_LO = -A_HI;
    logic signed [EXT_W-1:0] wide;
    assign wide  = EXT_W'(calg_q) <<< EA;
    // hold within +-2^62
    assign acc_d = (wide > A_HI) ? ACC_W'(A_HI) :
                   (wide < A_LO) ? ACC_W'(A_LO) : ACC_W'(wide);
  end else begin : g_acc_dn
    localparam int EK = -EA;
    localparam logic signed [X_W-1:0] A_RND = X_W'(1) <<< (EK - 1);
    logic signed [X_W-1:0] wide;
    // round half up; the result stays far inside +-2^62
    assign wide  = (X_W'(calg_q) + A_RND) >>> EK;
    assign acc_d = ACC_W'(wide);
  end

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      d_q    <= op_i.sub_cd ? (D_W'(pab_q) - D_W'(pcd_q)) : (D_W'(pab_q) + D_W'(pcd_q));
      acc1_q <= acc_d;
    end
  end

  // Stage 2: scale vector component to Q29 within +-2^40
  logic signed [VW-1:0]    vw;
  logic signed [VS_W-1:0]  vs_q;
  logic signed [ACC_W-1:0] acc2_q;

  if (EV >= 0) begin : g_vec_up
    assign vw = VW'(d_q) <<< EV;
  end else begin : g_vec_dn
    localparam int EK = -EV;
    localparam logic signed [VW-1:0] V_RND = VW'(1) <<< (EK - 1);
    assign vw = (VW'(d_q) + V_RND) >>> EK;
  end

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      vs_q   <= (vw > V_HI) ? VS_W'(V_HI) : (vw < V_LO) ? VS_W'(V_LO) : VS_W'(vw);
      acc2_q <= acc1_q;
    end
  end

  // Stage 3: apply offset and saturate to 32 bits
  logic signed [VS_W-1:0]  vt;
  logic signed [OUT_W-1:0] vert3_q, vert_sat;
  logic signed [ACC_W-1:0] acc3_q;

  assign vt       = vs_q - (op_i.sub_one ? ONE_Q29 : '0);
  assign vert_sat = (&vt[VS_W-1:OUT_W-1] || ~|vt[VS_W-1:OUT_W-1]) ? vt[OUT_W-1:0] :
                    {vt[VS_W-1], {(OUT_W-1){~vt[VS_W-1]}}};

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      vert3_q <= vert_sat;
      acc3_q  <= acc2_q;
    end
  end

  // Stage 4: remove gravity, round to Q16
  logic signed [X_W-1:0]   x;
  logic signed [RA_W-1:0]  ra_q;
  logic signed [OUT_W-1:0] vert4_q;

  assign x = X_W'(acc3_q) - X_W'(vert3_q) + RA_RND;

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      ra_q    <= RA_W'(x >>> RA_SHIFT);
      vert4_q <= vert3_q;
    end
  end

  // Stage 5: partial products of vector times gravity-free acceleration
  logic signed [PPL_W-1:0] pp_lo_q;
  logic signed [PPH_W-1:0] pp_hi_q;
  logic signed [OUT_W-1:0] vert5_q;

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      pp_lo_q <= vert4_q * $signed({1'b0, ra_q[RA_LO_W-1:0]});
      pp_hi_q <= vert4_q * $signed(ra_q[RA_W-1:RA_LO_W]);
      vert5_q <= vert4_q;
    end
  end

  // Stage 6: sum partial products, saturate to 64 bits
  logic signed [FULL_W-1:0] full;
  logic signed [PROD_W-1:0] prod_q, prod_sat;
  logic signed [OUT_W-1:0]  vert6_q;

  assign full     = (FULL_W'(pp_hi_q) <<< RA_LO_W) + FULL_W'(pp_lo_q);
  assign prod_sat = (&full[FULL_W-1:PROD_W-1] || ~|full[FULL_W-1:PROD_W-1]) ?
                    full[PROD_W-1:0] : {full[FULL_W-1], {(PROD_W-1){~full[FULL_W-1]}}};

  always_ff @(posedge clk_i) begin
    if (en_i[6]) begin
      prod_q  <= prod_sat;
      vert6_q <= vert5_q;
    end
  end

  assign vert_o = vert6_q;
  assign prod_o = prod_q;

endmodule

[hdl/ivau_merge.sv]
module ivau_merge
  import ivau_pkg::*;
#(
  parameter int G_TO_MS_Q16 = 642689
) (
  input  logic                     clk_i,
  input  logic [MERGE_STAGES-1:0]  en_i,
  input  logic signed [PROD_W-1:0] prod_i [LANES],
  input  logic signed [OUT_W-1:0]  vert_i [LANES],
  output logic signed [OUT_W-1:0]  vert_o [LANES],
  output logic signed [OUT_W-1:0]  res_o
);

  localparam int G_W    = $clog2(G_TO_MS_Q16 + 1);
  localparam int GS_W   = G_W + 1;
  localparam int S_W    = PROD_W + 1;
  localparam int PL_W   = DOT_LO_W + 1 + GS_W;
  localparam int PH_W   = DOT_W - DOT_LO_W + GS_W;
  localparam int SUM_W  = DOT_W + GS_W + 1;

  localparam logic signed [GS_W-1:0]  G_S     = GS_W'(G_TO_MS_Q16);
  localparam logic signed [S_W-1:0]   DOT_RND = S_W'(1) <<< (DOT_SHIFT - 1);
  localparam logic signed [SUM_W-1:0] RES_RND = SUM_W'(1) <<< (RES_SHIFT - 1);

  // Vector components travel alongside the dot product
  logic signed [OUT_W-1:0] vert_q [MERGE_STAGES][LANES];

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      vert_q[0] <= vert_i;
    end
    for (int k = 1; k < MERGE_STAGES; k++) begin
      if (en_i[k]) begin
        vert_q[k] <= vert_q[k-1];
      end
    end
  end

  // Stage 0: saturating add of the first two lanes
  logic signed [S_W-1:0]    s01;
  logic signed [PROD_W-1:0] s01_q, p2_q;

  assign s01 = S_W'(prod_i[0]) + S_W'(prod_i[1]);

  always_ff @(posedge clk_i) begin
    if (en_i[0]) begin
      s01_q <= (s01[S_W-1] == s01[S_W-2]) ? s01[PROD_W-1:0] :
               {s01[S_W-1], {(PROD_W-1){~s01[S_W-1]}}};
      p2_q  <= prod_i[2];
    end
  end

  // Stage 1: saturating add of the third lane
  logic signed [S_W-1:0]    s;
  logic signed [PROD_W-1:0] s_q;

  assign s = S_W'(s01_q) + S_W'(p2_q);

  always_ff @(posedge clk_i) begin
    if (en_i[1]) begin
      s_q <= (s[S_W-1] == s[S_W-2]) ? s[PROD_W-1:0] : {s[S_W-1], {(PROD_W-1){~s[S_W-1]}}};
    end
  end

  // Stage 2: round dot product to Q24
  logic signed [S_W-1:0]   t;
  logic signed [DOT_W-1:0] dot_q;

  assign t = S_W'(s_q) + DOT_RND;

  always_ff @(posedge clk_i) begin
    if (en_i[2]) begin
      dot_q <= DOT_W'(t >>> DOT_SHIFT);
    end
  end

  // Stage 3: partial products of the unit conversion
  logic signed [PL_W-1:0] pl_q;
  logic signed [PH_W-1:0] ph_q;

  always_ff @(posedge clk_i) begin
    if (en_i[3]) begin
      pl_q <= $signed({1'b0, dot_q[DOT_LO_W-1:0]}) * G_S;
      ph_q <= $signed(dot_q[DOT_W-1:DOT_LO_W]) * G_S;
    end
  end

  // Stage 4: sum partial products
  logic signed [SUM_W-1:0] sum_q;

  always_ff @(posedge clk_i) begin
    if (en_i[4]) begin
      sum_q <= (SUM_W'(ph_q) <<< DOT_LO_W) + SUM_W'(pl_q);
    end
  end

  // Stage 5: round to Q16 and saturate to 32 bits
  logic signed [SUM_W-1:0] r;
  logic signed [OUT_W-1:0] res_q;

  assign r = (sum_q + RES_RND) >>> RES_SHIFT;

  always_ff @(posedge clk_i) begin
    if (en_i[5]) begin
      res_q <= (&r[SUM_W-1:OUT_W-1] || ~|r[SUM_W-1:OUT_W-1]) ? r[OUT_W-1:0] :
               {r[SUM_W-1], {(OUT_W-1){~r[SUM_W-1]}}};
    end
  end

  assign vert_o = vert_q[MERGE_STAGES-1];
  assign res_o  = res_q;

endmodule

[hdl/imu_vertical_acceleration_unit.sv]
// Channel   | Dir | Handshake                    | Payload
// s_axis    | in  | s_axis_tvalid/s_axis_tready  | accel_x/y/z, quat_w/x/y/z (176 bits)
// m_axis    | out | m_axis_tvalid/m_axis_tready  | vert_x/y/z, vert_accel (128 bits)
// cfg       | in  | cfg_we_i, no back-pressure   | cfg_idx_i, cfg_data_i (16 bits)
//
// One item per cycle while m_axis takes results; each item passes through 7 lane stages
// and 6 merge stages. The 32x32 quaternion products and the split 32x51 dot-product
// multiply in each axis lane set the stage count.
// Reset clears the stage valid bits and loads the register reset values.
// A stall on m_axis holds only the stages that are full; bubbles ahead of the
// stall still close up, so input is taken while a result waits if a stage is empty.
module imu_vertical_acceleration_unit
  import ivau_pkg::*;
#(
  parameter int BIAS_SHIFT     = 6,
  parameter int SCALE_SHIFT    = 7,
  parameter int ACCEL_SHIFT    = 12,
  parameter int QUAT_FRAC_BITS = 30,
  parameter int G_TO_MS_Q16    = 642689
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 s_axis_tvalid,
  output logic                 s_axis_tready,
  // accel_x, accel_y, accel_z, quat_w, quat_x, quat_y, quat_z
  input  logic [IN_W-1:0]      s_axis_tdata,
  output logic                 m_axis_tvalid,
  input  logic                 m_axis_tready,
  // vert_x, vert_y, vert_z, vert_accel
  output logic [OUT_DW-1:0]    m_axis_tdata,
  input  logic                 cfg_we_i,
  input  logic [CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [CFG_W-1:0]     cfg_data_i
);

  localparam logic signed [GAIN_W-1:0] GAIN_ONE = GAIN_W'(1) <<< SCALE_SHIFT;

  // Configuration registers; the gain is stored with its implicit one added
  logic signed [CFG_W-1:0]  bias_q [LANES];
  logic signed [GAIN_W-1:0] gain_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      bias_q[0] <= '0;
      bias_q[1] <= '0;
      bias_q[2] <= '0;
      gain_q    <= GAIN_ONE;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        REG_BIAS_X:     bias_q[0] <= cfg_data_i;
        REG_BIAS_Y:     bias_q[1] <= cfg_data_i;
        REG_BIAS_Z:     bias_q[2] <= cfg_data_i;
        REG_SCALE_WORD: gain_q    <= GAIN_W'($signed(cfg_data_i)) + GAIN_ONE;
        default: begin
        end
      endcase
    end
  end

  // Unpack the input item
  logic signed [RAW_W-1:0]  raw [LANES];
  logic signed [QUAT_W-1:0] qw, qx, qy, qz;

  assign raw[0] = s_axis_tdata[RAW_W-1:0];
  assign raw[1] = s_axis_tdata[2*RAW_W-1:RAW_W];
  assign raw[2] = s_axis_tdata[3*RAW_W-1:2*RAW_W];
  assign qw     = s_axis_tdata[3*RAW_W+QUAT_W-1:3*RAW_W];
  assign qx     = s_axis_tdata[3*RAW_W+2*QUAT_W-1:3*RAW_W+QUAT_W];
  assign qy     = s_axis_tdata[3*RAW_W+3*QUAT_W-1:3*RAW_W+2*QUAT_W];
  assign qz     = s_axis_tdata[3*RAW_W+4*QUAT_W-1:3*RAW_W+3*QUAT_W];

  // Pipeline control
  pipe_en_t en;

  ivau_pipe_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid),
    .in_ready_o  (s_axis_tready),
    .out_valid_o (m_axis_tvalid),
    .out_ready_i (m_axis_tready),
    .en_o        (en)
  );

  // Lane operands: x = xz - wy, y = yz + wx, z = ww + zz - 1
  logic signed [QUAT_W-1:0] qa [LANES], qb [LANES], qc [LANES], qd [LANES];
  lane_op_t                 op [LANES];

  assign qa[0] = qx;  assign qb[0] = qz;  assign qc[0] = qw;  assign qd[0] = qy;
  assign qa[1] = qy;  assign qb[1] = qz;  assign qc[1] = qw;  assign qd[1] = qx;
  assign qa[2] = qw;  assign qb[2] = qw;  assign qc[2] = qz;  assign qd[2] = qz;
  assign op[0] = '{sub_cd: 1'b1, sub_one: 1'b0};
  assign op[1] = '{sub_cd: 1'b0, sub_one: 1'b0};
  assign op[2] = '{sub_cd: 1'b0, sub_one: 1'b1};

  logic signed [OUT_W-1:0]  lane_vert [LANES];
  logic signed [PROD_W-1:0] lane_prod [LANES];

  for (genvar i = 0; i < LANES; i++) begin : g_lane
    ivau_lane #(
      .BIAS_SHIFT     (BIAS_SHIFT),
      .SCALE_SHIFT    (SCALE_SHIFT),
      .ACCEL_SHIFT    (ACCEL_SHIFT),
      .QUAT_FRAC_BITS (QUAT_FRAC_BITS)
    ) u_lane (
      .clk_i  (clk_i),
      .en_i   (en.lane_en),
      .op_i   (op[i]),
      .raw_i  (raw[i]),
      .bias_i (bias_q[i]),
      .gain_i (gain_q),
      .qa_i   (qa[i]),
      .qb_i   (qb[i]),
      .qc_i   (qc[i]),
      .qd_i   (qd[i]),
      .vert_o (lane_vert[i]),
      .prod_o (lane_prod[i])
    );
  end

  // Merge the lanes into the vertical acceleration
  logic signed [OUT_W-1:0] vert_out [LANES];
  logic signed [OUT_W-1:0] res;

  ivau_merge #(
    .G_TO_MS_Q16 (G_TO_MS_Q16)
  ) u_merge (
    .clk_i  (clk_i),
    .en_i   (en.merge_en),
    .prod_i (lane_prod),
    .vert_i (lane_vert),
    .vert_o (vert_out),
    .res_o  (res)
  );

  assign m_axis_tdata = {res, vert_out[2], vert_out[1], vert_out[0]};

endmodule

[hdl/ivau_sva_chk.sv]
module ivau_sva_chk
  import ivau_pkg::*;
(
  input logic              clk_i,
  input logic              rst_ni,
  input logic              s_axis_tvalid,
  input logic              s_axis_tready,
  input logic              m_axis_tvalid,
  input logic              m_axis_tready,
  input logic [OUT_DW-1:0] m_axis_tdata
);

  localparam int CNT_W = $clog2(PIPE_DEPTH + 2);

  // Track items taken in but not yet delivered
  logic [CNT_W-1:0] cnt_q, cnt_d;
  logic             in_acc, out_acc;

  assign in_acc  = s_axis_tvalid && s_axis_tready;
  assign out_acc = m_axis_tvalid && m_axis_tready;
  assign cnt_d   = cnt_q + CNT_W'(in_acc) - CNT_W'(out_acc);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  // A stalled result holds its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata))
    else $error("result changed while stalled");

  // No result without an item in flight
  a_no_phantom: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> cnt_q != '0)
    else $error("result with no item in flight");

  // Occupancy never exceeds the pipeline depth
  a_depth: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CNT_W'(PIPE_DEPTH))
    else $error("more items in flight than stages");

  // A draining output always leaves room for a new item
  a_flow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tready |-> s_axis_tready)
    else $error("input blocked while output drains");

endmodule

bind imu_vertical_acceleration_unit ivau_sva_chk u_sva_chk (
  .clk_i         (clk_i),
  .rst_ni        (rst_ni),
  .s_axis_tvalid (s_axis_tvalid),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata)
);
